// ===== hdl/h264gr_pkg.sv =====
`default_nettype none

package h264gr_pkg;

    localparam int BUFFER_BITS_DEF = 128;

    localparam int KIND_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 6;
    localparam int LOW_W    = 32;
    localparam int HIGH_W   = 33;
    localparam int VALUE_W  = 33;
    localparam int STATUS_W = 2;

    // widest fixed read and longest Exp-Golomb code
    localparam int MAX_FIXED = 32;
    localparam int PEEK_W    = 63;
    localparam int LZ_W      = 5;

    localparam logic [BYTE_W-1:0] EMU_BYTE = 8'h03;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH  = 2'd0,
        KIND_FIXED = 2'd1,
        KIND_UEV   = 2'd2,
        KIND_SEV   = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_FULL  = 2'd2,
        ST_START = 2'd3
    } t_status;

    // leading zeros of a 31-bit window, 31 when the window is all zero
    function automatic logic [LZ_W-1:0] clz31(input logic [30:0] v);
        logic [LZ_W-1:0] lz;
        lz = LZ_W'(31);
        for (int i = 0; i < 31; i++) begin
            if (v[i]) begin
                lz = LZ_W'(30 - i);
            end
        end
        return lz;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/h264_bitstream_golomb_reader_core.sv =====
`default_nettype none

// Bit reader for an H.264 NAL payload. A push beat (tuser kind 0) offers one stream byte:
// after two zero bytes a 0x03 is dropped as emulation prevention and a byte of 0x00..0x02
// is refused with status 3 (start code); other bytes are appended MSB first to a
// BUFFER_BITS-bit FIFO, or refused with status 2 when they do not fit. Read beats take a
// fixed field of 0..32 bits, larger counts reading 32 (kind 1), an unsigned
// Exp-Golomb code clipped to clip_high (kind 2) or a signed Exp-Golomb code clipped to
// clip_low..clip_high (kind 3); a read that lacks bits returns status 1 and leaves the
// FIFO untouched. Every input beat yields exactly one output beat. The block takes one
// beat per cycle unless the output stalls: an input register, then the leading-zero count
// and FIFO barrel shifters, which also update the FIFO state, into the output register.
module h264_bitstream_golomb_reader_core #(
    parameter int BUFFER_BITS = h264gr_pkg::BUFFER_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // byte_in[7:0], bit_count[13:8], clip_low[45:14], clip_high[78:46], zero[79]
    input  wire logic [79:0] i_s_axis_tdata,
    // kind[1:0]
    input  wire logic [1:0]  i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // value[32:0], zero[39:33]
    output logic [39:0]      o_m_axis_tdata,
    // status[1:0]
    output logic [1:0]       o_m_axis_tuser
);
    import h264gr_pkg::*;

    localparam int HELD_W = $clog2(BUFFER_BITS + 1);

    // input register
    logic                     r_in_valid;
    t_kind                    r_kind;
    logic [BYTE_W-1:0]        r_byte;
    logic [COUNT_W-1:0]       r_cnt;
    logic signed [LOW_W-1:0]  r_lo;
    logic signed [HIGH_W-1:0] r_hi;

    // FIFO state
    logic [BUFFER_BITS-1:0] r_buf, n_buf;
    logic [HELD_W-1:0]      r_held, n_held;
    logic [1:0]             r_zero_run, n_zero_run;

    // output register
    logic                      r_out_valid;
    logic signed [VALUE_W-1:0] r_value, n_value;
    t_status                   r_status, n_status;

    logic w_adv;
    logic w_s_acc;

    logic [PEEK_W-1:0]      w_top;
    logic [LZ_W-1:0]        w_lz;
    logic [COUNT_W-1:0]     w_len;
    logic [COUNT_W-1:0]     w_cnt_sat;
    logic [COUNT_W-1:0]     w_take;
    logic [PEEK_W-1:0]      w_peek;
    logic [31:0]            w_field;
    logic [31:0]            w_ue;
    logic                   w_short;
    logic [BUFFER_BITS-1:0] w_push_vec;
    logic signed [VALUE_W-1:0] w_uev;
    logic signed [VALUE_W-1:0] w_sev;
    logic signed [VALUE_W-1:0] w_sev_lo;
    logic signed [VALUE_W-1:0] w_lo_ext;

    assign w_adv           = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_adv;
    assign w_s_acc         = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_s_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_kind <= t_kind'(i_s_axis_tuser[1:0]);
            r_byte <= i_s_axis_tdata[7:0];
            r_cnt  <= i_s_axis_tdata[13:8];
            r_lo   <= i_s_axis_tdata[45:14];
            r_hi   <= i_s_axis_tdata[78:46];
        end
    end

    // head of the FIFO sits at the top bit; bits past r_held stay zero
    assign w_top     = r_buf[BUFFER_BITS-1 -: PEEK_W];
    assign w_lz      = clz31(w_top[PEEK_W-1 -: 31]);
    assign w_len     = {w_lz, 1'b1};
    assign w_cnt_sat = (r_cnt > COUNT_W'(MAX_FIXED)) ? COUNT_W'(MAX_FIXED) : r_cnt;
    assign w_take    = (r_kind == KIND_FIXED) ? w_cnt_sat : w_len;
    assign w_peek    = w_top >> (COUNT_W'(PEEK_W) - w_take);
    assign w_field   = w_peek[31:0];
    assign w_ue      = w_field - 32'd1;
    assign w_short   = HELD_W'(w_take) > r_held;
    assign w_push_vec = {r_byte, {(BUFFER_BITS-BYTE_W){1'b0}}} >> r_held;

    assign w_lo_ext = {r_lo[LOW_W-1], r_lo};
    assign w_uev    = {1'b0, w_ue};
    // odd codes map to ue/2+1, even codes to -(ue/2)
    assign w_sev    = w_ue[0] ? (VALUE_W'(w_ue[31:1]) + VALUE_W'(1))
                              : (VALUE_W'(0) - VALUE_W'(w_ue[31:1]));
    assign w_sev_lo = (w_sev < w_lo_ext) ? w_lo_ext : w_sev;

    always_comb begin
        n_buf      = r_buf;
        n_held     = r_held;
        n_zero_run = r_zero_run;
        n_value    = '0;
        n_status   = ST_OK;
        case (r_kind)
            KIND_PUSH: begin
                if (r_zero_run == 2'd2 && r_byte == EMU_BYTE) begin
                    n_zero_run = 2'd0;
                end else if (r_zero_run == 2'd2 && r_byte < EMU_BYTE) begin
                    n_status = ST_START;
                end else if (r_held > HELD_W'(BUFFER_BITS - BYTE_W)) begin
                    n_status = ST_FULL;
                end else begin
                    n_buf  = r_buf | w_push_vec;
                    n_held = r_held + HELD_W'(BYTE_W);
                    if (r_byte == '0) begin
                        n_zero_run = (r_zero_run == 2'd2) ? 2'd2 : r_zero_run + 2'd1;
                    end else begin
                        n_zero_run = 2'd0;
                    end
                end
            end
            KIND_FIXED, KIND_UEV, KIND_SEV: begin
                if (w_short) begin
                    n_status = ST_SHORT;
                end else begin
                    n_buf  = r_buf << w_take;
                    n_held = r_held - HELD_W'(w_take);
                    if (r_kind == KIND_FIXED) begin
                        n_value = {1'b0, w_field};
                    end else if (r_kind == KIND_UEV) begin
                        n_value = (w_uev > r_hi) ? r_hi : w_uev;
                    end else begin
                        n_value = (w_sev_lo > r_hi) ? r_hi : w_sev_lo;
                    end
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf      <= '0;
            r_held     <= '0;
            r_zero_run <= 2'd0;
        end else if (w_adv) begin
            r_buf      <= n_buf;
            r_held     <= n_held;
            r_zero_run <= n_zero_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_value  <= n_value;
            r_status <= n_status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_value};
    assign o_m_axis_tuser  = r_status;

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= HELD_W'(BUFFER_BITS))
        else $error("held bit count exceeds buffer size");

    a_tail_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_buf << r_held) == '0)
        else $error("stale bits past the FIFO tail");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_held) && $stable(r_zero_run) && $stable(r_buf))
        else $error("FIFO state moved without a beat");

    a_fail_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && n_status != ST_OK |=> $stable(r_held) && $stable(r_zero_run))
        else $error("refused beat changed FIFO state");

endmodule

`default_nettype wire

// ===== verif/tb_golomb_checker.sv =====
`timescale 1ns / 100ps

module tb_golomb_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [79:0] i_s_tdata,
    input  logic [1:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,
    input  logic [1:0]  i_m_tuser,
    output int          o_fail_count,
    output int          o_pending
);
    import h264gr_pkg::*;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        t_status            status;
    } t_decoded;

    // shadow of the bit FIFO: head of the stream sits at the MSB
    logic [BUFFER_BITS_DEF-1:0] stream_bits;
    int unsigned                stream_len;
    int unsigned                zero_bytes;

    t_decoded decoded_q[$];
    int       mismatches = 0;

    assign o_fail_count = mismatches;

    // pop n bits off the head of the stream, right-aligned: the first bit lands in bit n-1
    function automatic logic [63:0] take_bits(input int unsigned n);
        logic [63:0] bits;
        bits = 64'(stream_bits >> (BUFFER_BITS_DEF - n));
        stream_bits = stream_bits << n;
        stream_len  = stream_len - n;
        return bits;
    endfunction

    function automatic t_decoded decode_beat(
        input t_kind              kind,
        input logic [7:0]         byte_in,
        input logic [5:0]         bit_count,
        input logic signed [31:0] clip_low,
        input logic signed [32:0] clip_high
    );
        t_decoded           res;
        logic signed [63:0] val;
        logic [31:0]        ue;
        int unsigned        width;
        int unsigned        lz;
        bit                 short_read;
        res.status = ST_OK;
        val        = '0;
        short_read = 0;
        case (kind)
            KIND_PUSH: begin
                if (zero_bytes >= 2 && byte_in == EMU_BYTE) begin
                    zero_bytes = 0;
                end else if (zero_bytes >= 2 && byte_in < EMU_BYTE) begin
                    res.status = ST_START;
                end else if (stream_len + 8 > BUFFER_BITS_DEF) begin
                    res.status = ST_FULL;
                end else begin
                    stream_bits[BUFFER_BITS_DEF-1-stream_len -: 8] = byte_in;
                    stream_len = stream_len + 8;
                    if (byte_in == 8'h00) begin
                        zero_bytes = (zero_bytes >= 2) ? 2 : zero_bytes + 1;
                    end else begin
                        zero_bytes = 0;
                    end
                end
            end
            KIND_FIXED: begin
                width = (bit_count > MAX_FIXED) ? MAX_FIXED : bit_count;
                if (width > stream_len) begin
                    res.status = ST_SHORT;
                end else begin
                    val = take_bits(width);
                end
            end
            default: begin
                lz = 0;
                while (lz < 31) begin
                    if (lz >= stream_len) begin
                        short_read = 1;
                        break;
                    end
                    if (stream_bits[BUFFER_BITS_DEF-1-lz]) break;
                    lz++;
                end
                if (!short_read && 2 * lz + 1 > stream_len) short_read = 1;
                if (short_read) begin
                    res.status = ST_SHORT;
                end else begin
                    ue = 32'(take_bits(2 * lz + 1) - 64'd1);
                    if (kind == KIND_UEV) begin
                        val = {32'b0, ue};
                        if (val > clip_high) val = clip_high;
                    end else begin
                        val = 64'(ue >> 1);
                        // odd codes map to positive, even codes to zero or negative
                        if (ue[0]) val = val + 1;
                        else val = -val;
                        if (val < clip_low) val = clip_low;
                        if (val > clip_high) val = clip_high;
                    end
                end
            end
        endcase
        res.value = val[VALUE_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_decoded exp_res;
        if (!i_rst_n) begin
            stream_bits = '0;
            stream_len  = 0;
            zero_bytes  = 0;
            decoded_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (decoded_q.size() == 0) begin
                    $error("result beat with nothing expected: value %0d status %0d",
                           $signed(i_m_tdata[VALUE_W-1:0]), i_m_tuser);
                    mismatches++;
                end else begin
                    exp_res = decoded_q.pop_front();
                    if (i_m_tdata[VALUE_W-1:0] !== exp_res.value) begin
                        $error("value: expected %0d, got %0d", $signed(exp_res.value),
                               $signed(i_m_tdata[VALUE_W-1:0]));
                        mismatches++;
                    end
                    if (i_m_tuser !== exp_res.status) begin
                        $error("status: expected %0d, got %0d", exp_res.status, i_m_tuser);
                        mismatches++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                decoded_q.push_back(decode_beat(t_kind'(i_s_tuser), i_s_tdata[7:0],
                                                i_s_tdata[13:8], i_s_tdata[45:14],
                                                i_s_tdata[78:46]));
            end
        end
        o_pending <= decoded_q.size();
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import h264gr_pkg::*;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    int fail_count;
    int pending;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    // two zeros then an escape byte, twice over, with a start code and another escape between
    logic [7:0] escape_run[13] = '{8'h00, 8'h00, 8'h03, 8'h00, 8'h00, 8'h01, 8'h03,
                                   8'h00, 8'h00, 8'h03, 8'h00, 8'h00, 8'h80};

    always #5 clk = ~clk;

    h264_bitstream_golomb_reader_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    tb_golomb_checker checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    function automatic logic signed [31:0] random_low();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10) return 32'sd0;
        if (r < 20) return -32'sd2147483647;
        if (r < 50) return -32'($urandom_range(20));
        if (r < 90) return -32'($urandom_range(2147483647));
        return $urandom;
    endfunction

    function automatic logic signed [32:0] random_high();
        int unsigned r;
        int          near_zero;
        r = $urandom_range(99);
        near_zero = $urandom_range(40);
        if (r < 10) return 33'sd4294967294;
        if (r < 15) return -33'sd2147483647;
        if (r < 40) return 33'(near_zero - 20);
        if (r < 70) return {1'b0, 32'($urandom)};
        if (r < 90) return 33'(-longint'($urandom_range(2147483647)));
        return {1'($urandom_range(1)), 32'($urandom)};
    endfunction

    function automatic logic [7:0] random_stream_byte();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 30) return 8'h00;
        if (r < 40) return EMU_BYTE;
        if (r < 48) return 8'($urandom_range(2, 1));
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [5:0] random_count();
        if ($urandom_range(99) < 5) begin
            return $urandom_range(1) ? 6'd0 : 6'($urandom_range(63, 33));
        end
        return 6'($urandom_range(32, 1));
    endfunction

    // called at a rising edge; returns at the edge where the beat is taken
    task automatic offer_beat(input t_kind kind, input logic [7:0] byte_in,
                              input logic [5:0] bit_count,
                              input logic signed [31:0] clip_low,
                              input logic signed [32:0] clip_high);
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, clip_high, clip_low, bit_count, byte_in};
        s_tuser  <= kind;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic push_byte(input logic [7:0] byte_in);
        offer_beat(KIND_PUSH, byte_in, random_count(), random_low(), random_high());
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    initial begin
        int sent;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer_beat(KIND_FIXED, 8'h00, 6'd5, 32'sd0, 33'sd0);
        offer_beat(KIND_UEV, 8'hFF, 6'd1, -32'sd2147483647, 33'sd4294967294);
        push_byte(8'hFF);
        offer_beat(KIND_FIXED, 8'h55, 6'd0, 32'sd0, 33'sd0);
        offer_beat(KIND_FIXED, 8'hAA, 6'd63, 32'sd0, 33'sd0);
        offer_beat(KIND_FIXED, 8'h00, 6'd1, 32'sd0, 33'sd0);
        offer_beat(KIND_UEV, 8'h00, 6'd0, 32'sd0, -33'sd2147483647);
        offer_beat(KIND_SEV, 8'h00, 6'd0, 32'sd0, 33'sd0);
        offer_beat(KIND_FIXED, 8'h00, 6'd5, 32'sd0, 33'sd0);
        foreach (escape_run[i]) push_byte(escape_run[i]);
        // 64 zero bits ahead of the 1: the prefix count stops at 31
        offer_beat(KIND_UEV, 8'h00, 6'd32, 32'sd0, 33'sd4294967294);
        offer_beat(KIND_SEV, 8'h00, 6'd32, -32'sd2147483647, 33'sd4294967294);
        hold_until_drained();

        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 61 : 0;
            rx_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 37 : 0;
            sent = 0;
            while (sent < 570) begin
                repeat ($urandom_range(20, 1)) begin
                    push_byte(random_stream_byte());
                    sent++;
                end
                repeat ($urandom_range(10, 1)) begin
                    offer_beat(t_kind'($urandom_range(3, 1)), 8'($urandom_range(255)),
                               random_count(), random_low(), random_high());
                    sent++;
                end
            end
            hold_until_drained();
        end

        repeat (4) @(posedge clk);
        if (fail_count == 0) begin
            $display("PASS h264_bitstream_golomb_reader_core");
        end else begin
            $display("FAIL h264_bitstream_golomb_reader_core");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAIL h264_bitstream_golomb_reader_core");
        $finish;
    end

endmodule

// ===== h264_bitstream_golomb_reader_core.f =====
hdl/h264gr_pkg.sv
hdl/h264_bitstream_golomb_reader_core.sv
verif/tb_golomb_checker.sv
verif/tb_top.sv
